// ----- sv/lru_pkg.sv -----
// Package with the shared types and constants of the LRU page replacement block.
package lru_pkg;

  localparam int PAGE_W       = 10;
  localparam int CFG_W        = 5;
  localparam int OCC_W        = 5;
  localparam int CAPACITY_DEF = 16;
  localparam int PAGES_DEF    = 1024;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef enum logic {
    KIND_ACCESS = 1'b0,
    KIND_EVICT  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [PAGE_W-1:0] page;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic              victim_valid;
    logic [PAGE_W-1:0] victim_page;
    status_e           status;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

endpackage

// ----- sv/lru_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lru_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lru_page_replacement_top.sv -----
// Top level of the LRU page replacement block: recency order, presence map and control.
// Each item's presence map read is issued at the accept edge; then, in S_EXEC, the item
// updates the recency order and the presence map and loads the result register.
// A new item is accepted in the cycle in which the previous one completes in S_EXEC, so
// items flow at one per cycle as long as the result register drains; a held result
// stalls the second item until it is taken. The presence map is a RAM of PAGES bits;
// after reset it is swept to zero one entry per cycle (PAGES entries, 1024 by default)
// while the input stays stalled. The page is matched to all valid recency entries at once.
// Configuration writes are taken at any time, including during the sweep.
module lru_page_replacement_top #(
  parameter int CAPACITY = lru_pkg::CAPACITY_DEF,
  parameter int PAGES    = lru_pkg::PAGES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  lru_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output lru_pkg::out_item_t         out_item_o,
  input  logic                       cfg_we_i,
  input  logic [lru_pkg::CFG_W-1:0]  cfg_wdata_i
);

  localparam int PW   = $clog2(PAGES);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > lru_pkg::CFG_W) ? CW : lru_pkg::CFG_W;
  localparam int PGW  = lru_pkg::PAGE_W;

  // Reduce a page number modulo PAGES by conditional subtraction of scaled divisors
  function automatic logic [PGW-1:0] page_mod(input logic [PGW-1:0] p);
    logic [PGW-1:0] r;
    r = p;
    for (int k = PGW - 1; k >= 0; k--) begin
      if ((PAGES << k) < (1 << PGW)) begin
        if (int'(r) >= (PAGES << k)) begin
          r = r - PGW'(PAGES << k);
        end
      end
    end
    return r;
  endfunction

  lru_pkg::state_e state_q, state_d;

  logic [lru_pkg::CFG_W-1:0] cap_q;
  logic [PW-1:0]             clr_cnt_q;
  logic [CW-1:0]             count_q, count_d;
  logic [PGW-1:0]            order_q [CAPACITY];
  logic [PGW-1:0]            order_d [CAPACITY];
  logic [PGW-1:0]            nxt     [CAPACITY];
  lru_pkg::kind_e            kind_q;
  logic [PGW-1:0]            page_q;
  logic                      fwd_hit_q, fwd_bit_q;
  logic                      out_valid_q;
  lru_pkg::out_item_t        out_item_q, res;

  logic            accept, exec_fire, clearing, clr_last;
  logic [PGW-1:0]  in_page;
  logic [PW-1:0]   rd_addr;
  logic            rd_bit, present, full;
  logic [CAPACITY-1:0] match, seen;
  logic            upd_we, upd_bit;
  logic [PGW-1:0]  upd_page;
  logic            ram_we, ram_wdata;
  logic [PW-1:0]   ram_waddr;

  // Handshake and control outputs of the sequencer
  always_comb begin
    clearing  = (state_q == lru_pkg::S_CLEAR);
    clr_last  = (clr_cnt_q == PW'(PAGES - 1));
    exec_fire = (state_q == lru_pkg::S_EXEC) && (!out_valid_q || !out_stall_i);
    in_stall_o = clearing || ((state_q == lru_pkg::S_EXEC) && !exec_fire);
    accept    = in_valid_i && !in_stall_o;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lru_pkg::S_CLEAR: begin
        if (clr_last) state_d = lru_pkg::S_IDLE;
      end
      lru_pkg::S_IDLE: begin
        if (accept) state_d = lru_pkg::S_EXEC;
      end
      lru_pkg::S_EXEC: begin
        if (exec_fire && !accept) state_d = lru_pkg::S_IDLE;
      end
      default: state_d = lru_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lru_pkg::S_CLEAR;
      clr_cnt_q <= '0;
      cap_q     <= lru_pkg::CAP_RESET;
      count_q   <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_cnt_q <= clr_cnt_q + PW'(1);
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (exec_fire) count_q <= count_d;
    end
  end

  // Presence map lookup address for an incoming item
  assign in_page = page_mod(in_item_i.page);
  assign rd_addr = PW'(in_page);

  // Latch the item and any write that lands on the address being read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= in_item_i.kind;
      page_q    <= in_page;
      fwd_hit_q <= ram_we && (ram_waddr == rd_addr);
      fwd_bit_q <= ram_wdata;
    end
  end

  assign present = fwd_hit_q ? fwd_bit_q : rd_bit;

  // Match the page against valid recency entries and mark entries at or after it
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CW'(i) < count_q) && (order_q[i] == page_q);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      seen[i] = |(match & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i)));
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      nxt[i] = order_q[i + 1];
    end
    nxt[CAPACITY-1] = order_q[CAPACITY-1];
    full = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q == CW'(CAPACITY));
  end

  // Update recency order, count and presence map for the item in flight
  always_comb begin
    order_d  = order_q;
    count_d  = count_q;
    upd_we   = 1'b0;
    upd_bit  = 1'b0;
    upd_page = page_q;
    res      = '0;
    res.status = lru_pkg::STATUS_OK;
    unique case (kind_q)
      lru_pkg::KIND_ACCESS: begin
        if (present) begin
          res.hit = 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (count_q == CW'(i + 1)) begin
              order_d[i] = page_q;
            end else if (seen[i] && (CW'(i + 1) < count_q)) begin
              order_d[i] = nxt[i];
            end
          end
        end else if (full) begin
          res.status = lru_pkg::STATUS_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (count_q == CW'(i)) order_d[i] = page_q;
          end
          count_d = count_q + CW'(1);
          upd_we  = 1'b1;
          upd_bit = 1'b1;
        end
      end
      lru_pkg::KIND_EVICT: begin
        if (count_q == '0) begin
          res.status = lru_pkg::STATUS_EMPTY;
        end else begin
          res.victim_valid = 1'b1;
          res.victim_page  = order_q[0];
          for (int i = 0; i < CAPACITY; i++) begin
            order_d[i] = nxt[i];
          end
          count_d  = count_q - CW'(1);
          upd_we   = 1'b1;
          upd_bit  = 1'b0;
          upd_page = order_q[0];
        end
      end
      default: res.status = lru_pkg::STATUS_OK;
    endcase
    res.occupancy = lru_pkg::OCC_W'(count_d);
  end

  // Advance the recency order
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      order_q <= order_d;
    end
  end

  // Presence map write: clearing sweep first, then item updates
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = exec_fire && upd_we;
      ram_waddr = PW'(upd_page);
      ram_wdata = upd_bit;
    end
  end

  lru_ram #(
    .WIDTH(1),
    .DEPTH(PAGES)
  ) u_present (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(rd_bit)
  );

  // Result register: load on completion, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- sv/lru_chk.sv -----
// Port-level checker for the LRU page replacement block, bound to the top level.
module lru_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input lru_pkg::out_item_t out_item_i
);

  logic                      out_take;
  logic [lru_pkg::OCC_W-1:0] occ_q;

  assign out_take = out_valid_i && !out_stall_i;

  // Track occupancy reported by the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (out_take) begin
      occ_q <= out_item_i.occupancy;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_item_i))
    else $error("result changed while stalled");

  a_victim_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.victim_valid |->
      out_item_i.status == lru_pkg::STATUS_OK && !out_item_i.hit)
    else $error("victim reported together with hit or error");

  a_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.victim_valid |-> out_item_i.victim_page == '0)
    else $error("victim page set without a victim");

  a_occ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && (out_item_i.hit || out_item_i.status != lru_pkg::STATUS_OK) |->
      out_item_i.occupancy == occ_q)
    else $error("occupancy changed on hit or error");

  a_occ_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && out_item_i.victim_valid |->
      out_item_i.occupancy == occ_q - lru_pkg::OCC_W'(1))
    else $error("occupancy not decremented on evict");

endmodule

bind lru_page_replacement_top lru_chk u_lru_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_i (out_item_o)
);
